/* sv/osc_pkg.sv */
// Shared types, codes and constants of the orthogonal SNR chi-square block.
package osc_pkg;

	localparam int DIV_ITERS = 24;
	localparam int DIV_CNT_W = 5;
	localparam logic [47:0] SUM_MAX = {48{1'b1}};
	localparam logic [4:0] MAX_DOF_RST = 5'd10;
	localparam logic [4:0] ORTHO_COUNT_RST = 5'd16;

	typedef enum logic [1:0] {
		MODE_MATRIX = 2'd0,
		MODE_ORTHO  = 2'd1,
		MODE_SNR    = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic {
		REG_MAX_DOF     = 1'b0,
		REG_ORTHO_COUNT = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_DIV,
		ST_DIFF,
		ST_MUL,
		ST_ACC,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic [3:0]         row;
		logic [5:0]         column;
		logic signed [31:0] value;
		logic               gap;
	} in_item_t;

	typedef struct packed {
		logic [47:0] chisq;
		logic [5:0]  channel;
		logic        overflow;
		logic        zero_divisor;
	} out_item_t;

	typedef struct packed {
		logic ram_wr;
		logic ort_wr;
		logic calc_start;
		logic load;
		logic div_step;
		logic diff;
		logic mul;
		logic acc;
		logic zero_hit;
	} cmd_t;

	typedef struct packed {
		logic divisor_zero;
	} status_t;

endpackage

/* sv/osc_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module osc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* sv/osc_ctrl.sv */
// Controller state machine: sequences matrix reads, division and accumulation per term.
module osc_ctrl import osc_pkg::*; #(
	parameter int ORTHO_MAX = 16,
	parameter int SNR_MAX   = 64
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	input  in_item_t                                 item,
	input  logic [4:0]                               max_dof,
	input  logic [4:0]                               ortho_count,
	input  status_t                                  status,
	output cmd_t                                     cmd,
	output logic [(ORTHO_MAX > 1 ? $clog2(ORTHO_MAX) : 1)-1:0] k,
	output logic                                     busy,
	output logic                                     done
);

	localparam int KW = ORTHO_MAX > 1 ? $clog2(ORTHO_MAX) : 1;
	localparam int CW = KW + 1;

	state_t              state_q, state_d;
	logic [KW-1:0]       k_q;
	logic [DIV_CNT_W-1:0] it_q;
	logic [4:0]          dmin;
	logic [CW-1:0]       dof;
	logic                last_term;
	logic                accept;
	logic                col_ok;
	logic                row_ok;

	assign accept = start && (state_q == ST_IDLE);
	assign col_ok = 32'(item.column) < SNR_MAX;
	assign row_ok = 32'(item.row) < ORTHO_MAX;
	assign dmin = (max_dof < ortho_count) ? max_dof : ortho_count;
	assign dof = (32'(dmin) > ORTHO_MAX) ? CW'(ORTHO_MAX) : CW'(dmin);
	assign last_term = ({1'b0, k_q} + CW'(1)) == dof;
	assign k = k_q;
	assign busy = state_q != ST_IDLE;
	assign done = state_q == ST_DONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q <= '0;
			it_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				k_q <= '0;
			end else if ((state_q == ST_ACC) || (state_q == ST_LOAD && status.divisor_zero)) begin
				k_q <= k_q + KW'(1);
			end
			if (state_q == ST_LOAD) begin
				it_q <= '0;
			end else if (state_q == ST_DIV) begin
				it_q <= it_q + DIV_CNT_W'(1);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (item.mode)
						MODE_MATRIX: cmd.ram_wr = row_ok && col_ok;
						MODE_ORTHO:  cmd.ort_wr = row_ok;
						MODE_SNR: begin
							cmd.calc_start = 1'b1;
							if (item.gap || !col_ok || dof == '0) begin
								state_d = ST_DONE;
							end else begin
								state_d = ST_READ;
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_READ: state_d = ST_LOAD;
			ST_LOAD: begin
				if (status.divisor_zero) begin
					cmd.zero_hit = 1'b1;
					state_d = last_term ? ST_DONE : ST_READ;
				end else begin
					cmd.load = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (it_q == DIV_CNT_W'(DIV_ITERS - 1)) begin
					state_d = ST_DIFF;
				end
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = last_term ? ST_DONE : ST_READ;
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

/* sv/osc_dp.sv */
// Datapath: stores, shared radix-4 divider, squarer and saturating accumulator.
module osc_dp import osc_pkg::*; #(
	parameter int ORTHO_MAX = 16,
	parameter int SNR_MAX   = 64
) (
	input  logic                                     clk,
	input  in_item_t                                 item,
	input  cmd_t                                     cmd,
	input  logic [(ORTHO_MAX > 1 ? $clog2(ORTHO_MAX) : 1)-1:0] k,
	output status_t                                  status,
	output out_item_t                                result
);

	localparam int KW = ORTHO_MAX > 1 ? $clog2(ORTHO_MAX) : 1;
	localparam int DEPTH = ORTHO_MAX * SNR_MAX;
	localparam int AW = DEPTH > 1 ? $clog2(DEPTH) : 1;

	logic [31:0]        ortho_q [ORTHO_MAX];
	logic [31:0]        rdata;
	logic [AW-1:0]      waddr;
	logic [AW-1:0]      raddr;
	logic signed [31:0] snr_q;
	logic [5:0]         chan_q;
	logic [31:0]        den_q;
	logic [31:0]        rem_q;
	logic [47:0]        quo_q;
	logic               neg_q;
	logic [31:0]        mag_q;
	logic               sat_q;
	logic [63:0]        prod_q;
	logic [47:0]        sum_q;
	logic               ovf_q;
	logic               zdiv_q;
	logic [31:0]        ortho_cur;
	logic [31:0]        den_d;
	logic [31:0]        onum;
	logic [31:0]        rem_d;
	logic [47:0]        quo_d;
	logic [32:0]        trial;
	logic signed [49:0] qs;
	logic signed [49:0] dif;
	logic [49:0]        dmag;
	logic [48:0]        sum_ext;

	assign waddr = AW'(AW'(item.row) * AW'(SNR_MAX) + AW'(item.column));
	assign raddr = AW'(AW'(k) * AW'(SNR_MAX) + AW'(chan_q));

	osc_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_matrix (
		.clk  (clk),
		.we   (cmd.ram_wr),
		.waddr(waddr),
		.wdata(item.value),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign status.divisor_zero = rdata == '0;
	assign ortho_cur = ortho_q[k];
	assign den_d = rdata[31] ? 32'(-rdata) : rdata;
	assign onum = ortho_cur[31] ? 32'(-ortho_cur) : ortho_cur;

	// Two restoring steps per cycle.
	always_comb begin
		rem_d = rem_q;
		quo_d = quo_q;
		trial = '0;
		for (int i = 0; i < 2; i++) begin
			trial = {rem_d, quo_d[47]};
			quo_d = {quo_d[46:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				trial = trial - {1'b0, den_q};
				quo_d[0] = 1'b1;
			end
			rem_d = trial[31:0];
		end
	end

	always_comb begin
		qs = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
		dif = qs - 50'(snr_q);
		dmag = dif[49] ? 50'(-dif) : 50'(dif);
	end

	assign sum_ext = {1'b0, sum_q} + {1'b0, prod_q[63:16]};

	always_ff @(posedge clk) begin
		if (cmd.ort_wr) begin
			ortho_q[KW'(item.row)] <= item.value;
		end
		if (cmd.calc_start) begin
			snr_q <= item.value;
			chan_q <= item.column;
			sum_q <= '0;
			ovf_q <= 1'b0;
			zdiv_q <= 1'b0;
		end
		if (cmd.load) begin
			den_q <= den_d;
			rem_q <= '0;
			quo_q <= {onum, 16'h0000};
			neg_q <= ortho_cur[31] ^ rdata[31];
		end
		if (cmd.div_step) begin
			rem_q <= rem_d;
			quo_q <= quo_d;
		end
		if (cmd.diff) begin
			mag_q <= dmag[31:0];
			sat_q <= |dmag[49:32];
		end
		if (cmd.mul) begin
			prod_q <= mag_q * mag_q;
		end
		if (cmd.zero_hit) begin
			sum_q <= SUM_MAX;
			ovf_q <= 1'b1;
			zdiv_q <= 1'b1;
		end
		if (cmd.acc) begin
			if (sat_q || sum_ext[48]) begin
				sum_q <= SUM_MAX;
				ovf_q <= 1'b1;
			end else begin
				sum_q <= sum_ext[47:0];
			end
		end
	end

	assign result.chisq = sum_q;
	assign result.channel = chan_q;
	assign result.overflow = ovf_q;
	assign result.zero_divisor = zdiv_q;

endmodule

/* sv/orthogonal_snr_chisquare.sv */
// Top level of the orthogonal SNR chi-square discriminator.
//
// An item is accepted at a rising edge where start is high and busy is low.
// Mode 0 writes one mixing matrix entry, mode 1 stores one orthogonal SNR
// value; neither makes the block busy nor gives a result. Mode 3 is dropped.
// Mode 2 carries the SNR of one channel and gives one result on the result
// port, marked by done for exactly one cycle. The receiver cannot stall it.
// A gap item, an out-of-range channel or zero degrees of freedom gives a zero
// result in the cycle straight after acceptance.
// Otherwise each of the dof terms goes through a matrix read and load, the
// shared divider retiring two quotient bits per cycle, then difference,
// squaring and accumulation. A zero matrix entry skips its term after the
// read and load. The next item can be taken in the cycle after the done
// cycle; busy stays high from acceptance until the done cycle has passed.
// The APB port holds max_dof (address 0) and ortho_count (address 4); write
// them only while the block is idle. Reset sets them to 10 and 16 and
// returns the controller to idle; the stores hold garbage until written.
module orthogonal_snr_chisquare import osc_pkg::*; #(
	parameter int ORTHO_MAX = 16,
	parameter int SNR_MAX   = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_item_t    item,
	output logic        done,
	output out_item_t   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int KW = ORTHO_MAX > 1 ? $clog2(ORTHO_MAX) : 1;

	logic [4:0]    max_dof_q;
	logic [4:0]    ortho_count_q;
	logic          cfg_wr;
	cmd_t          cmd;
	status_t       status;
	logic [KW-1:0] k;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// Register file: decoded on the word address bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dof_q <= MAX_DOF_RST;
			ortho_count_q <= ORTHO_COUNT_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[2]))
				REG_MAX_DOF:     max_dof_q <= pwdata[4:0];
				REG_ORTHO_COUNT: ortho_count_q <= pwdata[4:0];
				default:         max_dof_q <= max_dof_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[2]))
			REG_MAX_DOF:     prdata = {27'd0, max_dof_q};
			REG_ORTHO_COUNT: prdata = {27'd0, ortho_count_q};
			default:         prdata = '0;
		endcase
	end

	osc_ctrl #(.ORTHO_MAX(ORTHO_MAX), .SNR_MAX(SNR_MAX)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.item       (item),
		.max_dof    (max_dof_q),
		.ortho_count(ortho_count_q),
		.status     (status),
		.cmd        (cmd),
		.k          (k),
		.busy       (busy),
		.done       (done)
	);

	osc_dp #(.ORTHO_MAX(ORTHO_MAX), .SNR_MAX(SNR_MAX)) u_dp (
		.clk   (clk),
		.item  (item),
		.cmd   (cmd),
		.k     (k),
		.status(status),
		.result(result)
	);

endmodule

/* sv/osc_checker.sv */
// Port-level assertions for the chi-square block, bound to its top level.
module osc_checker import osc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input in_item_t  item,
	input logic      done,
	input out_item_t result
);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result strobe while idle");

	a_snr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.mode == MODE_SNR) |=> busy)
		else $error("SNR item did not start work");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.mode != MODE_SNR) |=> (!busy && !done))
		else $error("store item made the block busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");

	a_zero_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.zero_divisor) |-> (result.overflow && result.chisq == SUM_MAX))
		else $error("zero divisor without saturation");

endmodule

bind orthogonal_snr_chisquare osc_checker u_osc_checker (.*);

/* tb/sv/testbench.sv */
// Self-checking testbench for the orthogonal SNR chi-square discriminator.
`timescale 1ns / 1ps

module testbench import osc_pkg::*; ();

	// Keeps its own copy of the matrix, the orthogonal values and both
	// registers. It works out the result of each accepted SNR item and
	// compares the block's results against them in order.
	class chisq_board;
		logic signed [31:0] matrix[16][64];
		logic signed [31:0] ortho[16];
		logic [4:0] max_dof;
		logic [4:0] ortho_count;
		out_item_t pending[$];
		int errors;
		int checked;
		int zdiv_seen;
		int ovf_seen;

		function new();
			max_dof = MAX_DOF_RST;
			ortho_count = ORTHO_COUNT_RST;
			errors = 0;
			checked = 0;
			zdiv_seen = 0;
			ovf_seen = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [31:0] v);
			if (idx == REG_MAX_DOF) begin
				max_dof = v[4:0];
			end else begin
				ortho_count = v[4:0];
			end
		endfunction

		// Updates the stores for write items and queues the chi-square sum
		// that an SNR item should give.
		function void note_item(in_item_t it);
			out_item_t r;
			int dof;
			longint o, m, s, q, d;
			longint unsigned mag, sum;
			case (mode_t'(it.mode))
				MODE_MATRIX: begin
					matrix[it.row][it.column] = it.value;
				end
				MODE_ORTHO: begin
					ortho[it.row] = it.value;
				end
				MODE_SNR: begin
					r = '0;
					r.channel = it.column;
					sum = 0;
					if (!it.gap) begin
						dof = (max_dof < ortho_count) ? max_dof : ortho_count;
						if (dof > 16) begin
							dof = 16;
						end
						s = it.value;
						for (int k = 0; k < dof; k++) begin
							m = matrix[k][it.column];
							o = ortho[k];
							if (m == 0) begin
								// A zero divisor saturates its term and flags both.
								r.zero_divisor = 1'b1;
								r.overflow = 1'b1;
								sum = SUM_MAX;
							end else begin
								q = (o * 65536) / m;
								d = q - s;
								mag = (d < 0) ? -d : d;
								if (mag >= 64'h1_0000_0000) begin
									r.overflow = 1'b1;
									sum = SUM_MAX;
								end else begin
									sum = sum + ((mag * mag) >> 16);
									if (sum > SUM_MAX) begin
										sum = SUM_MAX;
										r.overflow = 1'b1;
									end
								end
							end
						end
					end
					r.chisq = sum[47:0];
					pending.push_back(r);
				end
				default: begin
				end
			endcase
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (pending.size() == 0) begin
				$error("result for channel %0d arrived with nothing outstanding", got.channel);
				errors++;
				return;
			end
			want = pending.pop_front();
			checked++;
			if (want.zero_divisor) begin
				zdiv_seen++;
			end
			if (want.overflow) begin
				ovf_seen++;
			end
			if (got.chisq !== want.chisq) begin
				$error("chisq: expected %h, got %h", want.chisq, got.chisq);
				errors++;
			end
			if (got.channel !== want.channel) begin
				$error("channel: expected %0d, got %0d", want.channel, got.channel);
				errors++;
			end
			if (got.overflow !== want.overflow) begin
				$error("overflow: expected %b, got %b", want.overflow, got.overflow);
				errors++;
			end
			if (got.zero_divisor !== want.zero_divisor) begin
				$error("zero_divisor: expected %b, got %b", want.zero_divisor,
					got.zero_divisor);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_item_t item;
	logic done;
	out_item_t result;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	chisq_board board;
	int items_sent;
	bit idle_enable;

	orthogonal_snr_chisquare dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
	end

	always #4 clk = ~clk;

	// Results cannot be stalled, so every done cycle is checked as it comes.
	always @(posedge clk) begin
		if (arst_n && done) begin
			board.check_result(result);
		end
	end

	// Offers one item from a falling edge. busy only moves at rising edges,
	// so seeing it low here means the item is taken at the next rising edge.
	task automatic send_item(in_item_t it);
		@(negedge clk);
		start = 1'b1;
		item = it;
		while (busy) begin
			@(negedge clk);
		end
		board.note_item(it);
		items_sent++;
		// Leave start high into the next item unless an idle gap is drawn.
		if (idle_enable && $urandom_range(99) < 35) begin
			@(negedge clk);
			start = 1'b0;
			item = '0;
			repeat ($urandom_range(3)) begin
				@(negedge clk);
			end
		end
	endtask

	task automatic stop_items();
		@(negedge clk);
		start = 1'b0;
		item = '0;
	endtask

	// Setup and access write on the register port; the block is idle when called.
	task automatic reg_write(reg_idx_t idx, logic [31:0] v);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {idx, 2'b00};
		pwdata = v;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		board.set_reg(idx, v);
	endtask

	// Waits until every queued result has come back and the block is free.
	task automatic drain();
		stop_items();
		while (board.pending.size() != 0 || busy) begin
			@(negedge clk);
		end
		repeat (4) begin
			@(negedge clk);
		end
	endtask

	// A mix of small values that keep terms in range, full-range values that
	// push them to saturation, and the two extremes of the signed field.
	function automatic logic [31:0] draw_value(bit allow_zero);
		int pick;
		pick = $urandom_range(99);
		if (allow_zero && pick < 4) begin
			return '0;
		end else if (pick < 55) begin
			return $urandom_range(32'h001F_FFFF) - 32'h0010_0000;
		end else if (pick < 85) begin
			return $urandom;
		end else if (pick < 92) begin
			return 32'h7FFF_FFFF;
		end else begin
			return 32'h8000_0000;
		end
	endfunction

	// SNR items from draw_item use the lowest eight and the highest eight
	// channels, whose matrix columns are filled before any SNR item is sent.
	function automatic logic [5:0] filled_column(int unsigned n);
		return (n < 8) ? 6'(n) : 6'(n + 48);
	endfunction

	function automatic in_item_t draw_item();
		in_item_t it;
		int pick;
		pick = $urandom_range(99);
		it.row = 4'($urandom_range(15));
		it.column = 6'($urandom_range(63));
		it.gap = ($urandom_range(9) == 0);
		if (pick < 25) begin
			it.mode = MODE_MATRIX;
			it.value = draw_value(1'b1);
		end else if (pick < 50) begin
			it.mode = MODE_ORTHO;
			it.value = draw_value(1'b0);
		end else if (pick < 95) begin
			it.mode = MODE_SNR;
			it.column = filled_column($urandom_range(15));
			it.value = draw_value(1'b0);
		end else begin
			it.mode = MODE_NONE;
			it.value = $urandom;
		end
		return it;
	endfunction

	function automatic in_item_t make_item(mode_t md, int r, int c, logic [31:0] v,
		logic g);
		in_item_t it;
		it.mode = md;
		it.row = 4'(r);
		it.column = 6'(c);
		it.value = v;
		it.gap = g;
		return it;
	endfunction

	initial begin
		int dof_list[7];
		int cnt_list[7];
		board = new();
		items_sent = 0;
		idle_enable = 1'b1;
		start = 1'b0;
		item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		repeat (2) begin
			@(posedge clk);
		end
		@(negedge clk);
		arst_n = 1'b1;

		// Fill every orthogonal value and the matrix columns that SNR items
		// use, so that no SNR item ever reads an entry that was never written.
		for (int r = 0; r < 16; r++) begin
			send_item(make_item(MODE_ORTHO, r, 0, draw_value(1'b0), 1'b0));
			for (int c = 0; c < 16; c++) begin
				send_item(make_item(MODE_MATRIX, r, filled_column(c), draw_value(1'b0),
					1'b0));
			end
		end

		// Directed items: field extremes, a zero divisor, a gap, mode 3 and
		// a term that stays well inside range.
		send_item(make_item(MODE_ORTHO, 0, 0, 32'h0001_0000, 1'b0));
		send_item(make_item(MODE_MATRIX, 0, 5, 32'h0001_0000, 1'b0));
		send_item(make_item(MODE_SNR, 0, 5, 32'h0000_8000, 1'b0));
		send_item(make_item(MODE_SNR, 0, 5, 32'h7FFF_FFFF, 1'b0));
		send_item(make_item(MODE_SNR, 0, 5, 32'h8000_0000, 1'b0));
		send_item(make_item(MODE_SNR, 15, 5, 32'hFFFF_FFFF, 1'b1));
		send_item(make_item(MODE_MATRIX, 15, 63, 32'h8000_0000, 1'b1));
		send_item(make_item(MODE_ORTHO, 15, 63, 32'h7FFF_FFFF, 1'b1));
		send_item(make_item(MODE_SNR, 0, 63, 32'h0000_0000, 1'b0));
		send_item(make_item(MODE_MATRIX, 3, 7, 32'h0000_0000, 1'b0));
		send_item(make_item(MODE_SNR, 0, 7, 32'h0002_0000, 1'b0));
		send_item(make_item(MODE_SNR, 0, 7, 32'h0002_0000, 1'b1));
		send_item(make_item(MODE_NONE, 15, 63, 32'hFFFF_FFFF, 1'b1));
		send_item(make_item(MODE_MATRIX, 3, 7, 32'hFFFF_0000, 1'b0));
		send_item(make_item(MODE_SNR, 0, 7, 32'hFFF0_0000, 1'b0));
		drain();

		// Register settings per phase: the reset values, both extremes of
		// each register, zero degrees of freedom and values above the clamp.
		dof_list = '{10, 16, 1, 16, 0, 31, 7};
		cnt_list = '{16, 16, 16, 1, 16, 31, 12};
		for (int ph = 0; ph < 7; ph++) begin
			if (ph > 0) begin
				reg_write(REG_MAX_DOF, dof_list[ph]);
				reg_write(REG_ORTHO_COUNT, cnt_list[ph]);
			end
			// One phase runs with no idle gaps at all.
			idle_enable = (ph != 2);
			for (int n = 0; n < 135; n++) begin
				send_item(draw_item());
			end
			drain();
		end
		reg_write(REG_ORTHO_COUNT, 0);
		for (int n = 0; n < 10; n++) begin
			send_item(make_item(MODE_SNR, 0, $urandom_range(63), $urandom, 1'b0));
		end
		drain();

		repeat (500) begin
			@(negedge clk);
		end
		$display("%0d items accepted under eight register settings; %0d results checked,",
			items_sent, board.checked);
		$display("%0d with a zero divisor and %0d saturated.", board.zdiv_seen,
			board.ovf_seen);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Far beyond the slowest correct run of sixteen-term items back to back.
	initial begin
		#20ms;
		$display("tb: failure");
		$finish;
	end

endmodule

/* files.f */
sv/osc_pkg.sv
sv/osc_ram.sv
sv/osc_ctrl.sv
sv/osc_dp.sv
sv/orthogonal_snr_chisquare.sv
sv/osc_checker.sv
tb/sv/testbench.sv
